[hw/rtl/lmq_pkg.sv]
// constants and types shared by the min/max uniform llr quantiser
`timescale 1ns / 1ps

package lmq_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned PAIR_W          = 8;
  localparam int unsigned BIN_W           = 8;
  localparam int unsigned LVL_W           = BIN_W + 1;
  localparam int unsigned USER_W          = 2;

  localparam logic [PAIR_W-1:0] PAIR_MAX = PAIR_W'(128);
  localparam logic [PAIR_W-1:0] PAIR_MIN = PAIR_W'(1);

  // tuser bit positions on the input side
  localparam int unsigned USER_ACTION = 0;
  localparam int unsigned USER_FIRST  = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_ROUND,
    ST_OUT
  } lmq_state_e;

endpackage

[hw/rtl/llr_minmax_uniform_quantizer.sv]
// min/max tracking uniform midpoint quantiser for signed llr samples
//
//  channel   dir  beat fields (lsb first)                 handshake
//  s_axis    in   tdata: sample, tuser: action, first     tvalid/tready
//  m_axis    out  tdata: quantized, bin_index             tvalid/tready
//  cfg       in   level_pairs                             cfg_we_i, no wait
//
//  a measure beat updates the tracked bounds and gives no result
//  a quantise beat closes the input until its result is stored: 8 bin divider steps and
//  SAMPLE_BITS midpoint steps; the bin steps are skipped at or beyond a tracked bound,
//  and neither runs before any measure or with a zero range
//  one item at a time; the output register lets the next beat in while a result waits,
//  and a second finished result holds the input until m_axis_tready frees the register
//  reset: level_pairs 1, tracking cleared, no result pending
`timescale 1ns / 1ps

module llr_minmax_uniform_quantizer #(
  parameter int unsigned SAMPLE_BITS = lmq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lmq_pkg::PAIR_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // action, first_of_block
  input  logic [lmq_pkg::USER_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // quantized, bin_index
  output logic [((SAMPLE_BITS+lmq_pkg::BIN_W+7)/8)*8-1:0] m_axis_tdata
);

  import lmq_pkg::*;

  localparam int unsigned W    = SAMPLE_BITS;
  localparam int unsigned ODW  = ((W + BIN_W + 7) / 8) * 8;
  localparam int unsigned RW   = W + LVL_W;
  localparam int unsigned CNTW = $clog2(W);

  localparam logic [W-1:0] MIN_RST = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAX_RST = {1'b1, {(W-1){1'b0}}};

  lmq_state_e state_q, state_d;

  logic                have_q, have_d;
  logic [W-1:0]        min_q, min_d;
  logic [W-1:0]        max_q, max_d;
  logic [PAIR_W-1:0]   pairs_q;
  logic                m_valid_q, m_valid_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;

  logic [W-1:0]        smp_q, smp_d;
  logic [W-1:0]        range_q, range_d;
  logic [W-1:0]        diff_q, diff_d;
  logic [BIN_W-1:0]    j_q, j_d;
  logic [RW-1:0]       rem_q, rem_d;
  logic [RW-1:0]       dvs_q, dvs_d;
  logic [W-1:0]        quo_q, quo_d;
  logic [W-1:0]        res_q, res_d;
  logic [BIN_W-1:0]    res_bin_q, res_bin_d;
  logic [W-1:0]        out_quant_q, out_quant_d;
  logic [BIN_W-1:0]    out_bin_q, out_bin_d;

  logic                s_fire;
  logic                in_action;
  logic                in_first;
  logic [W-1:0]        in_sample;
  logic [PAIR_W-1:0]   pairs_eff;
  logic [LVL_W-1:0]    lvl;
  logic [LVL_W+0:0]    four_p;
  logic [BIN_W-1:0]    lvl_m1;
  logic signed [W:0]   rng_w;
  logic signed [W:0]   dif_w;
  logic signed [W:0]   base_w;
  logic [W-1:0]        mul_a;
  logic [LVL_W-1:0]    mul_b;
  logic [RW-1:0]       prod;
  logic                take;
  logic [W-1:0]        quo_nxt;

  assign in_action = s_axis_tuser[USER_ACTION];
  assign in_first  = s_axis_tuser[USER_FIRST];
  assign in_sample = s_axis_tdata[W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = ODW'({out_bin_q, out_quant_q});

  always_comb begin
    priority if (pairs_q == '0) begin
      pairs_eff = PAIR_MIN;
    end else if (pairs_q > PAIR_MAX) begin
      pairs_eff = PAIR_MAX;
    end else begin
      pairs_eff = pairs_q;
    end
  end

  assign lvl    = {pairs_eff, 1'b0};
  assign four_p = {pairs_eff, 2'b00};
  assign lvl_m1 = BIN_W'(lvl - LVL_W'(1));

  assign rng_w  = $signed({max_q[W-1], max_q}) - $signed({min_q[W-1], min_q});
  assign dif_w  = $signed({smp_q[W-1], smp_q}) - $signed({min_q[W-1], min_q});
  assign base_w = $signed({min_q[W-1], min_q}) + $signed({1'b0, quo_q});

  // shared multiplier
  assign mul_a = (state_q == ST_MUL1) ? diff_q : range_q;
  assign mul_b = (state_q == ST_MUL1) ? lvl : {j_q, 1'b1};
  assign prod  = mul_a * mul_b;

  // one restoring step; the bin pass divides (d*L - 1) by comparing d*L strictly
  assign take    = (state_q == ST_DIV1) ? (rem_q > dvs_q) : (rem_q >= dvs_q);
  assign quo_nxt = {quo_q[W-2:0], take};

  always_comb begin
    state_d     = state_q;
    have_d      = have_q;
    min_d       = min_q;
    max_d       = max_q;
    m_valid_d   = m_valid_q;
    cnt_d       = cnt_q;
    smp_d       = smp_q;
    range_d     = range_q;
    diff_d      = diff_q;
    j_d         = j_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    res_d       = res_q;
    res_bin_d   = res_bin_q;
    out_quant_d = out_quant_q;
    out_bin_d   = out_bin_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          smp_d = in_sample;
          if (!in_action) begin
            have_d = 1'b1;
            if (in_first) begin
              min_d = in_sample;
              max_d = in_sample;
            end else begin
              if ($signed(in_sample) < $signed(min_q)) begin
                min_d = in_sample;
              end
              if ($signed(in_sample) > $signed(max_q)) begin
                max_d = in_sample;
              end
            end
          end else if (!have_q) begin
            res_d     = in_sample;
            res_bin_d = '0;
            state_d   = ST_OUT;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        range_d = rng_w[W-1:0];
        diff_d  = dif_w[W-1:0];
        priority if (rng_w == '0) begin
          res_d     = min_q;
          res_bin_d = '0;
          state_d   = ST_OUT;
        end else if (dif_w[W] || dif_w == '0) begin
          j_d     = '0;
          state_d = ST_MUL2;
        end else if (dif_w >= rng_w) begin
          j_d     = lvl_m1;
          state_d = ST_MUL2;
        end else begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        rem_d   = prod;
        dvs_d   = RW'(range_q) << (BIN_W - 1);
        quo_d   = '0;
        cnt_d   = CNTW'(BIN_W - 1);
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        if (take) begin
          rem_d = rem_q - dvs_q;
        end
        dvs_d = dvs_q >> 1;
        quo_d = quo_nxt;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          j_d     = quo_nxt[BIN_W-1:0];
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        rem_d   = prod;
        dvs_d   = RW'(four_p) << (W - 1);
        quo_d   = '0;
        cnt_d   = CNTW'(W - 1);
        state_d = ST_DIV2;
      end
      ST_DIV2: begin
        if (take) begin
          rem_d = rem_q - dvs_q;
        end
        dvs_d = dvs_q >> 1;
        quo_d = quo_nxt;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // truncation toward zero lifts a negative midpoint with a remainder
        res_d     = base_w[W-1:0] + W'(base_w[W] && (rem_q != '0));
        res_bin_d = j_q;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d   = 1'b1;
          out_quant_d = res_q;
          out_bin_d   = res_bin_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      have_q    <= 1'b0;
      min_q     <= MIN_RST;
      max_q     <= MAX_RST;
      pairs_q   <= PAIR_MIN;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      have_q    <= have_d;
      min_q     <= min_d;
      max_q     <= max_d;
      m_valid_q <= m_valid_d;
      cnt_q     <= cnt_d;
      if (cfg_we_i) begin
        pairs_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q       <= smp_d;
    range_q     <= range_d;
    diff_q      <= diff_d;
    j_q         <= j_d;
    rem_q       <= rem_d;
    dvs_q       <= dvs_d;
    quo_q       <= quo_d;
    res_q       <= res_d;
    res_bin_q   <= res_bin_d;
    out_quant_q <= out_quant_d;
    out_bin_q   <= out_bin_d;
  end

  // tracked bounds stay ordered once measured
  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> ($signed(min_q) <= $signed(max_q)))
    else $error("min above max");

  // bin index never reaches the level count
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL2) |-> ({1'b0, j_q} < lvl))
    else $error("bin index out of range");

  // midpoint remainder below the divisor after the last step
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rem_q < RW'(four_p)))
    else $error("divider remainder too large");

  // a quantise beat closes the input until its result is stored
  a_busy_after_quant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_action) |=> !s_axis_tready)
    else $error("input open during quantise");

endmodule

[tb/tb.sv]
// self-checking stream testbench for the min/max uniform llr quantiser
`timescale 1ns / 1ps

module tb;
  import lmq_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam int unsigned DATA_W      = ((SB + 7) / 8) * 8;
  localparam int unsigned RES_W       = ((SB + BIN_W + 7) / 8) * 8;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BEATS = 72;
  localparam longint      SMAX        = (longint'(1) << (SB - 1)) - 1;
  localparam longint      SMIN        = -(longint'(1) << (SB - 1));

  typedef enum logic {
    ACT_MEASURE  = 1'b0,
    ACT_QUANTISE = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [SB-1:0] value;
    logic [BIN_W-1:0]     bin;
  } level_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [PAIR_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic [USER_W-1:0] s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [RES_W-1:0]  m_axis_tdata;

  // predictor state
  logic [PAIR_W-1:0] pair_setting;
  longint            lowest;
  longint            highest;
  bit                measured;
  level_t            due_levels[$];

  int error_count  = 0;
  int quiet_cycles = 0;
  int rx_hold_left = 0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;

  llr_minmax_uniform_quantizer #(
    .SAMPLE_BITS(SB)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic level_t midpoint_of(input longint s);
    longint pairs;
    longint levels;
    longint span;
    longint d;
    longint j;
    longint q;
    level_t r;
    pairs = longint'(pair_setting);
    if (pairs < longint'(PAIR_MIN)) begin
      pairs = longint'(PAIR_MIN);
    end
    if (pairs > longint'(PAIR_MAX)) begin
      pairs = longint'(PAIR_MAX);
    end
    levels = 2 * pairs;
    span   = highest - lowest;
    r.bin  = '0;
    if (!measured) begin
      r.value = SB'(s);
    end else if (span <= 0) begin
      r.value = SB'(lowest);
    end else begin
      d = s - lowest;
      if (d <= 0) begin
        j = 0;
      end else if (d >= span) begin
        j = levels - 1;
      end else begin
        j = (d * levels - 1) / span;
      end
      q = (lowest * 2 * levels + (2 * j + 1) * span) / (2 * levels);
      r.value = SB'(q);
      r.bin   = BIN_W'(j);
    end
    return r;
  endfunction

  task automatic model_beat(input action_e act, input longint s, input bit first);
    if (act == ACT_QUANTISE) begin
      due_levels.push_back(midpoint_of(s));
    end else begin
      if (first) begin
        lowest  = s;
        highest = s;
      end else begin
        if (s < lowest) begin
          lowest = s;
        end
        if (s > highest) begin
          highest = s;
        end
      end
      measured = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result(input logic [RES_W-1:0] beat);
    level_t               want;
    logic signed [SB-1:0] got_value;
    logic [BIN_W-1:0]     got_bin;
    got_value = beat[SB-1:0];
    got_bin   = beat[SB +: BIN_W];
    if (due_levels.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing due: value %0d bin %0d",
                                got_value, got_bin));
    end else begin
      want = due_levels.pop_front();
      if (got_value !== want.value) begin
        report_mismatch($sformatf("quantized %0d, expected %0d", got_value, want.value));
      end
      if (got_bin !== want.bin) begin
        report_mismatch($sformatf("bin_index %0d, expected %0d", got_bin, want.bin));
      end
    end
  endtask

  task automatic send_beat(input action_e act, input longint s, input bit first);
    int                gap;
    logic [USER_W-1:0] user;
    gap = tx_idle_en ? $urandom_range(0, 11) : 0;
    user = '0;
    user[USER_ACTION] = act;
    user[USER_FIRST]  = first;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(unsigned'(SB'(s)));
    s_axis_tuser  <= user;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model_beat(act, s, first);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_pairs(input logic [PAIR_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pair_setting = v;
  endtask

  function automatic longint any_sample();
    return longint'($urandom_range(0, 65535)) + SMIN;
  endfunction

  task automatic test_passthrough();
    send_beat(ACT_QUANTISE, SMIN, 1'b0);
    send_beat(ACT_QUANTISE, SMAX, 1'b1);
    send_beat(ACT_QUANTISE, 0, 1'b1);
    send_beat(ACT_QUANTISE, -1, 1'b0);
  endtask

  task automatic test_first_measure();
    // no first flag, so tracking starts from the reset extremes
    send_beat(ACT_MEASURE, 10, 1'b0);
    send_beat(ACT_QUANTISE, 10, 1'b0);
    send_beat(ACT_QUANTISE, -5, 1'b0);
  endtask

  task automatic test_full_span();
    wait_drain();
    write_pairs(8'd0);
    send_beat(ACT_MEASURE, SMIN, 1'b1);
    send_beat(ACT_MEASURE, SMAX, 1'b0);
    send_beat(ACT_QUANTISE, SMIN, 1'b0);
    send_beat(ACT_QUANTISE, SMAX, 1'b0);
    send_beat(ACT_QUANTISE, 0, 1'b1);
    send_beat(ACT_QUANTISE, -1, 1'b0);
    send_beat(ACT_QUANTISE, 12345, 1'b0);
  endtask

  task automatic test_bin_edges();
    longint edges[9] = '{25, 26, 50, 75, 76, 100, -10, 200, 0};
    wait_drain();
    write_pairs(8'd2);
    send_beat(ACT_MEASURE, 0, 1'b1);
    send_beat(ACT_MEASURE, 100, 1'b0);
    foreach (edges[i]) begin
      send_beat(ACT_QUANTISE, edges[i], bit'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_block(output int n_sent);
    int     n;
    int     i;
    longint span;
    longint base;
    longint off;
    bit     keep_first;
    n          = $urandom_range(4, 24);
    span       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 65535);
    base       = any_sample();
    keep_first = ($urandom_range(0, 7) != 0);
    if (base + span > SMAX) begin
      base = SMAX - span;
    end
    n_sent = 2 * n;
    for (i = 0; i < n; i++) begin
      off = (i == 1) ? 0 : (i == 2) ? span : longint'($urandom_range(0, int'(span)));
      send_beat(ACT_MEASURE, base + off, (i == 0) && keep_first);
    end
    if ($urandom_range(0, 6) == 0) begin
      send_beat(action_e'($urandom_range(0, 1)), any_sample(), bit'($urandom_range(0, 1)));
      n_sent++;
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        off = any_sample();
      end else begin
        off = base + longint'($urandom_range(0, int'(span)));
      end
      send_beat(ACT_QUANTISE, off, bit'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_blocks();
    logic [PAIR_W-1:0] picks[6] = '{8'd0, 8'd1, 8'd128, 8'd255, 8'd127, 8'd64};
    int                sent;
    int                got;
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      write_pairs((p < 6) ? picks[p] : PAIR_W'($urandom_range(0, 255)));
      tx_idle_en = (p % 3 != 2);
      rx_idle_en = (p % 4 != 1);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        run_block(got);
        sent += got;
      end
    end
  endtask

  task automatic test_stall_and_pause();
    wait_drain();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    send_beat(ACT_MEASURE, any_sample(), 1'b1);
    send_beat(ACT_MEASURE, any_sample(), 1'b0);
    rx_hold_left = LONG_HOLD;
    repeat (30) send_beat(ACT_QUANTISE, any_sample(), 1'b0);
    // sender holds back until every due result is out
    wait_drain();
    tx_idle_en = 1'b1;
    repeat (10) send_beat(ACT_QUANTISE, any_sample(), 1'b0);
  endtask

  initial begin : result_sink
    int gap;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        while (rx_hold_left > 0) begin
          @(posedge clk_i);
          rx_hold_left--;
        end
      end
      gap = rx_idle_en ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("llr_minmax_uniform_quantizer regression: fail");
      $finish;
    end
  end

  initial begin
    pair_setting = PAIR_MIN;
    lowest       = SMAX;
    highest      = SMIN;
    measured     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_first_measure();
    test_full_span();
    test_bin_edges();
    test_random_blocks();
    test_stall_and_pause();
    wait_drain();
    if (error_count == 0) begin
      $display("llr_minmax_uniform_quantizer regression: pass");
    end else begin
      $display("llr_minmax_uniform_quantizer regression: fail");
    end
    $finish;
  end

endmodule
